[hw/rtl/wvs_pkg.sv]
// wvs_pkg: beat types, widths, register indexes and saturation helpers
// for the weighted vertex skinning block; no dependencies
package wvs_pkg;

  localparam int MulAW = 43;                 // vertex sum or weighted point
  localparam int MulBW = 25;                 // matrix entry or weight
  localparam int MulPW = MulAW + MulBW;      // full product width
  localparam int SumW  = 48;                 // running sum width
  localparam int CfgW  = 32;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] REG_TRANSLATION_X = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_TRANSLATION_Y = 1'd1;

  typedef struct packed {
    logic signed [31:0] local_x;
    logic signed [31:0] local_y;
    logic signed [31:0] deform_x;
    logic signed [31:0] deform_y;
    logic        [16:0] weight;
    logic signed [23:0] mat_a;
    logic signed [23:0] mat_b;
    logic signed [23:0] mat_c;
    logic signed [23:0] mat_d;
    logic signed [31:0] bone_pos_x;
    logic signed [31:0] bone_pos_y;
    logic               last_influence;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
  } out_item_t;

  // clamp a 49-bit value to the 48-bit signed range
  function automatic logic signed [SumW-1:0] sat48(input logic signed [SumW:0] v);
    logic signed [SumW-1:0] r;
    if (v[SumW] != v[SumW-1]) begin
      r = v[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      r = v[SumW-1:0];
    end
    return r;
  endfunction

  // clamp a 49-bit value to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [SumW:0] v);
    logic signed [31:0] r;
    if ((&v[SumW:31]) || !(|v[SumW:31])) begin
      r = v[31:0];
    end else begin
      r = v[SumW] ? {1'b1, 31'h0} : {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage

[hw/rtl/wvs_mul.sv]
// wvs_mul: shared signed multiplier with a registered product
// depends on wvs_pkg for operand widths
module wvs_mul (
  input  logic                                clk,
  input  logic signed [wvs_pkg::MulAW-1:0]    op_a,
  input  logic signed [wvs_pkg::MulBW-1:0]    op_b,
  output logic signed [wvs_pkg::MulPW-1:0]    prod
);

  logic signed [wvs_pkg::MulPW-1:0] prod_next;

  assign prod_next = op_a * op_b;

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

endmodule

[hw/rtl/weighted_vertex_skinning_2d.sv]
// weighted_vertex_skinning_2d: 2d linear blend skinning, one bone influence per beat
// depends on wvs_pkg and wvs_mul
// an accepted influence steps through ST_M0 to ST_M5 and ST_SUMY before the block is
//   ready again; a last influence also passes ST_OUT, where its result beat is registered
//   (held off while a previous result beat is held by out_stall)
// one influence at a time: no new one is taken until its sequence is done, set by the single
//   shared multiplier doing six products in turn per influence
// reset: rst (sync, active high) clears state, sums, translations and out_valid
module weighted_vertex_skinning_2d (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wvs_pkg::in_item_t                   in_data,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output wvs_pkg::out_item_t                  out_data,
  // config write port
  input  logic                                cfg_we,
  input  logic [wvs_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [wvs_pkg::CfgW-1:0]            cfg_data
);

  // sequencer codes: one multiplier product per step from ST_M0 to ST_M5
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M0   = 4'd1;  // a*vx
  localparam logic [3:0] ST_M1   = 4'd2;  // b*vy
  localparam logic [3:0] ST_M2   = 4'd3;  // c*vx, qx formed
  localparam logic [3:0] ST_M3   = 4'd4;  // d*vy
  localparam logic [3:0] ST_M4   = 4'd5;  // qx*w, qy formed
  localparam logic [3:0] ST_M5   = 4'd6;  // qy*w, sum_x updated
  localparam logic [3:0] ST_SUMY = 4'd7;  // sum_y updated
  localparam logic [3:0] ST_OUT  = 4'd8;  // result beat loaded

  localparam int SumW = wvs_pkg::SumW;
  localparam int PW   = wvs_pkg::MulPW;

  logic [3:0] state, state_next;

  // captured influence
  logic signed [32:0] vx, vy;
  logic        [16:0] weight;
  logic signed [23:0] mat_a, mat_b, mat_c, mat_d;
  logic signed [31:0] bone_pos_x, bone_pos_y;
  logic               item_last;

  // intermediate values
  logic signed [57:0] acc;
  logic signed [42:0] qx, qy;
  logic signed [SumW-1:0] sum_x, sum_y;
  logic signed [31:0] translation_x, translation_y;

  // multiplier operands and product
  logic signed [wvs_pkg::MulAW-1:0] op_a;
  logic signed [wvs_pkg::MulBW-1:0] op_b;
  logic signed [PW-1:0]             prod;

  logic in_take, out_take, out_load;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  // the output register is free, or drains at this edge
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      translation_x <= '0;
      translation_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wvs_pkg::REG_TRANSLATION_X: translation_x <= cfg_data;
        wvs_pkg::REG_TRANSLATION_Y: translation_y <= cfg_data;
      endcase
    end
  end

  // operand steering for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      ST_M0: begin
        op_a = {{10{vx[32]}}, vx};
        op_b = {mat_a[23], mat_a};
      end
      ST_M1: begin
        op_a = {{10{vy[32]}}, vy};
        op_b = {mat_b[23], mat_b};
      end
      ST_M2: begin
        op_a = {{10{vx[32]}}, vx};
        op_b = {mat_c[23], mat_c};
      end
      ST_M3: begin
        op_a = {{10{vy[32]}}, vy};
        op_b = {mat_d[23], mat_d};
      end
      ST_M4: begin
        op_a = qx;
        op_b = {8'b0, weight};
      end
      ST_M5: begin
        op_a = qy;
        op_b = {8'b0, weight};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  wvs_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // point transform: round(a*v + b*v) + bone_pos in one add, since
  // floor((x + bp*2^16) / 2^16) equals floor(x / 2^16) + bp
  logic signed [31:0]   bone_pos_sel;
  logic signed [PW-1:0] q_sum;
  assign bone_pos_sel = (state == ST_M2) ? bone_pos_x : bone_pos_y;
  assign q_sum = prod + {{(PW-58){acc[57]}}, acc}
               + {{(PW-48){bone_pos_sel[31]}}, bone_pos_sel, 16'h8000};

  // weighted accumulate, rounding folded in the same way
  logic signed [SumW-1:0] sum_sel;
  logic signed [PW-1:0]   w_sum;
  logic signed [SumW-1:0] sum_new;
  assign sum_sel = (state == ST_M5) ? sum_x : sum_y;
  assign w_sum = prod + PW'(32768)
               + {{(PW-SumW-16){sum_sel[SumW-1]}}, sum_sel, 16'h0};
  assign sum_new = wvs_pkg::sat48(w_sum[SumW+16:16]);

  // result: sums plus skeleton translation, clamped to 32 bits
  logic signed [SumW:0] ox_wide, oy_wide;
  assign ox_wide = {sum_x[SumW-1], sum_x} + {{(SumW-31){translation_x[31]}}, translation_x};
  assign oy_wide = {sum_y[SumW-1], sum_y} + {{(SumW-31){translation_y[31]}}, translation_y};

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_take) state_next = ST_M0;
      ST_M0:   state_next = ST_M1;
      ST_M1:   state_next = ST_M2;
      ST_M2:   state_next = ST_M3;
      ST_M3:   state_next = ST_M4;
      ST_M4:   state_next = ST_M5;
      ST_M5:   state_next = ST_SUMY;
      ST_SUMY: state_next = item_last ? ST_OUT : ST_IDLE;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture, vertex plus deform formed on the way in
  always_ff @(posedge clk) begin
    if (in_take) begin
      vx         <= {in_data.local_x[31], in_data.local_x}
                  + {in_data.deform_x[31], in_data.deform_x};
      vy         <= {in_data.local_y[31], in_data.local_y}
                  + {in_data.deform_y[31], in_data.deform_y};
      weight     <= in_data.weight;
      mat_a      <= in_data.mat_a;
      mat_b      <= in_data.mat_b;
      mat_c      <= in_data.mat_c;
      mat_d      <= in_data.mat_d;
      bone_pos_x <= in_data.bone_pos_x;
      bone_pos_y <= in_data.bone_pos_y;
      item_last  <= in_data.last_influence;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_M1 || state == ST_M3) begin
      acc <= prod[57:0];
    end
    if (state == ST_M2) begin
      qx <= q_sum[58:16];
    end
    if (state == ST_M4) begin
      qy <= q_sum[58:16];
    end
  end

  // running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
    end else if (state == ST_M5) begin
      sum_x <= sum_new;
    end else if (state == ST_SUMY) begin
      sum_y <= sum_new;
    end else if (out_load) begin
      sum_x <= '0;
      sum_y <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.world_x <= wvs_pkg::sat32(ox_wide);
      out_data.world_y <= wvs_pkg::sat32(oy_wide);
    end
  end

  // an accepted beat always starts the multiply sequence
  assert property (@(posedge clk) disable iff (rst) in_take |=> state == ST_M0)
    else $error("accepted beat did not start the sequence");

  // a result beat appears only out of the output step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("result beat raised outside the output step");

  // sums are cleared once the result is loaded
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> (sum_x == '0) && (sum_y == '0))
    else $error("sums not cleared after result");

  // a non-last influence never produces a result
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUMY) && !item_last |=> state == ST_IDLE)
    else $error("non-last influence went on to output");

endmodule

[dv/tb_weighted_vertex_skinning_2d.sv]
// tb_weighted_vertex_skinning_2d: self-checking bench for the 2d skinning block
// drives influence beats, predicts world positions in q16.16 and checks every result beat
// depends on wvs_pkg and weighted_vertex_skinning_2d
module tb_weighted_vertex_skinning_2d;
  timeunit 1ns;
  timeprecision 1ps;

  // a last influence runs the whole multiply sequence and the output step before its result beat shows up
  localparam int BlockLatency = 9;
  localparam int SettleCycles = BlockLatency + 3;
  localparam int DrainCycles  = BlockLatency + 7;
  // cycles with no beat moving on either side before the run is declared hung
  localparam int HangLimit    = 4000;

  localparam longint SumHi   = (longint'(1) <<< 47) - 1;
  localparam longint SumLo   = -(longint'(1) <<< 47);
  localparam longint WorldHi = 64'sd2147483647;
  localparam longint WorldLo = -64'sd2147483648;

  localparam logic [31:0] Q16One = 32'h0001_0000;
  localparam logic [23:0] MatOne = 24'h01_0000;
  localparam logic [31:0] Q16Max = 32'h7FFF_FFFF;
  localparam logic [31:0] Q16Min = 32'h8000_0000;
  localparam logic [23:0] MatMax = 24'h7F_FFFF;
  localparam logic [23:0] MatMin = 24'h80_0000;
  localparam logic [16:0] WUnit  = 17'd65536;
  localparam logic [16:0] WTop   = 17'h1_FFFF;

  logic clk;
  logic rst = 1'b1;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  wvs_pkg::in_item_t             in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  wvs_pkg::out_item_t            out_data;
  logic                          cfg_we = 1'b0;
  logic [wvs_pkg::CfgIdxW-1:0]   cfg_index = '0;
  logic [wvs_pkg::CfgW-1:0]      cfg_data = '0;

  weighted_vertex_skinning_2d dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow of the block: translations, running sums and pending world positions
  // ---------------------------------------------------------------------------
  logic signed [31:0]   shadow_trans_x;
  logic signed [31:0]   shadow_trans_y;
  longint               blend_x;
  longint               blend_y;
  wvs_pkg::out_item_t   expected_world[$];

  // bookkeeping shared by stimulus and checker
  int mismatch_count   = 0;
  int influences_sent  = 0;
  int results_due      = 0;   // last influences accepted, counted by the sender
  int results_checked  = 0;   // result beats matched against an expectation
  int settings_applied = 0;
  int sum_clamps       = 0;
  int world_clamps     = 0;
  int hang_cycles      = 0;

  // sender burst shaping and receiver stall pattern
  bit gaps_on    = 1'b1;
  int gap_max    = 10;
  int burst_left = 0;
  int stall_pct  = 0;
  int stall_span = 6;
  int stall_left = 0;

  // round half up to q16.16: add half an lsb, then floor
  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one influence: transform, offset by bone, weight, accumulate; emit on the last one
  task automatic skin_influence(input wvs_pkg::in_item_t it);
    longint             vx, vy, qx, qy, w, nx, ny, ox, oy;
    wvs_pkg::out_item_t pos;
    vx = longint'(it.local_x) + longint'(it.deform_x);
    vy = longint'(it.local_y) + longint'(it.deform_y);
    w  = longint'(it.weight);
    qx = round_q16(longint'(it.mat_a) * vx + longint'(it.mat_b) * vy) + longint'(it.bone_pos_x);
    qy = round_q16(longint'(it.mat_c) * vx + longint'(it.mat_d) * vy) + longint'(it.bone_pos_y);
    nx = blend_x + round_q16(qx * w);
    ny = blend_y + round_q16(qy * w);
    // the sums clamp to 48 bits after every addition, not only at the end
    if (nx > SumHi || nx < SumLo || ny > SumHi || ny < SumLo) sum_clamps++;
    blend_x = clamp_range(nx, SumLo, SumHi);
    blend_y = clamp_range(ny, SumLo, SumHi);
    if (it.last_influence) begin
      nx = blend_x + longint'(shadow_trans_x);
      ny = blend_y + longint'(shadow_trans_y);
      if (nx > WorldHi || nx < WorldLo || ny > WorldHi || ny < WorldLo) world_clamps++;
      ox = clamp_range(nx, WorldLo, WorldHi);
      oy = clamp_range(ny, WorldLo, WorldHi);
      pos.world_x = ox[31:0];
      pos.world_y = oy[31:0];
      expected_world.push_back(pos);
      blend_x = 0;
      blend_y = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // checker: samples both channels and the config port at every rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : world_check
    wvs_pkg::out_item_t want;
    bit                 moved;
    if (rst) begin
      shadow_trans_x = '0;
      shadow_trans_y = '0;
      blend_x        = 0;
      blend_y        = 0;
      hang_cycles    = 0;
    end else begin
      moved = 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          wvs_pkg::REG_TRANSLATION_X: shadow_trans_x = cfg_data;
          wvs_pkg::REG_TRANSLATION_Y: shadow_trans_y = cfg_data;
          default: ;
        endcase
      end
      // result beats first, so a beat is never matched against this edge's input
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_world.size() == 0) begin
          report_mismatch("result beat with nothing pending, world_x", out_data.world_x, '0);
        end else begin
          want = expected_world.pop_front();
          if (out_data.world_x !== want.world_x)
            report_mismatch("world_x", out_data.world_x, want.world_x);
          if (out_data.world_y !== want.world_y)
            report_mismatch("world_y", out_data.world_y, want.world_y);
          results_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        skin_influence(in_data);
      end
      hang_cycles = moved ? 0 : hang_cycles + 1;
      if (hang_cycles >= HangLimit) begin
        $display("%0t ns: no beat moved for %0d cycles", $time, HangLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver back-pressure: stall or run for random stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      out_stall  <= ($urandom_range(0, 99) < stall_pct);
      stall_left <= $urandom_range(1, stall_span);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sender side; every task is entered and left just after a rising edge
  // ---------------------------------------------------------------------------

  // one influence beat; valid stays up afterwards unless a gap ends the burst
  task automatic send_influence(input wvs_pkg::in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    influences_sent++;
    if (it.last_influence) results_due++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  // hold off the sender until every pending world position has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_checked < results_due);
  endtask

  // a non-last influence may still be in the pipe, so give it time to retire
  task automatic settle_idle();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_translation(input logic [31:0] tx, input logic [31:0] ty);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_index <= wvs_pkg::REG_TRANSLATION_X;
    cfg_data  <= tx;
    @(posedge clk);
    cfg_index <= wvs_pkg::REG_TRANSLATION_Y;
    cfg_data  <= ty;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_applied++;
  endtask

  function automatic wvs_pkg::in_item_t influence(
    input logic [31:0] lx, input logic [31:0] ly,
    input logic [31:0] dx, input logic [31:0] dy,
    input logic [16:0] w,
    input logic [23:0] a, input logic [23:0] b, input logic [23:0] c, input logic [23:0] d,
    input logic [31:0] px, input logic [31:0] py,
    input logic        last);
    wvs_pkg::in_item_t it;
    it.local_x        = lx;
    it.local_y        = ly;
    it.deform_x       = dx;
    it.deform_y       = dy;
    it.weight         = w;
    it.mat_a          = a;
    it.mat_b          = b;
    it.mat_c          = c;
    it.mat_d          = d;
    it.bone_pos_x     = px;
    it.bone_pos_y     = py;
    it.last_influence = last;
    return it;
  endfunction

  // uniform value in [-mag, mag] as a 32-bit two's complement pattern
  function automatic logic [31:0] spread(input int unsigned mag);
    logic [31:0] r;
    r = $urandom_range(0, 2 * mag);
    return r - mag;
  endfunction

  function automatic logic [31:0] any_q16();
    case ($urandom_range(0, 9))
      0:       return Q16Max;
      1:       return Q16Min;
      2:       return '0;
      3, 4:    return spread(50 << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] any_mat();
    logic [31:0] r;
    case ($urandom_range(0, 9))
      0:       r = {8'h00, MatMax};
      1:       r = {8'hFF, MatMin};
      2:       r = '0;
      3, 4:    r = spread(2 << 16);
      default: r = $urandom;
    endcase
    return r[23:0];
  endfunction

  function automatic logic [16:0] any_weight();
    case ($urandom_range(0, 9))
      0:             return '0;
      1:             return WUnit;
      2:             return WTop;
      3, 4, 5, 6:    return 17'($urandom_range(0, 65536));
      default:       return 17'($urandom_range(0, 131071));
    endcase
  endfunction

  // wide picks full-range and corner values; otherwise a plausible mesh influence
  function automatic wvs_pkg::in_item_t random_influence(input bit wide, input bit last);
    logic [31:0] ma, mb, mc, md;
    if (wide) begin
      return influence(any_q16(), any_q16(), any_q16(), any_q16(), any_weight(),
                       any_mat(), any_mat(), any_mat(), any_mat(),
                       any_q16(), any_q16(), last);
    end
    ma = spread(3 << 15);
    mb = spread(3 << 15);
    mc = spread(3 << 15);
    md = spread(3 << 15);
    return influence(spread(100 << 16), spread(100 << 16),
                     ($urandom_range(0, 2) == 0) ? spread(4 << 16) : '0,
                     ($urandom_range(0, 2) == 0) ? spread(4 << 16) : '0,
                     17'($urandom_range(0, 65536)),
                     ma[23:0], mb[23:0], mc[23:0], md[23:0],
                     spread(1000 << 16), spread(1000 << 16), last);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field corners, rounding ties and weight edges with translation still at reset
  task automatic test_directed_corners();
    gaps_on   = 1'b1;
    stall_pct = 20;
    // identity bone, unit weight
    send_influence(influence(Q16One, -Q16One * 2, '0, '0, WUnit,
                             MatOne, '0, '0, MatOne, '0, '0, 1'b1));
    send_influence(influence('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    // two half weights, the second bone rotated by 90 degrees and with a deform
    send_influence(influence(Q16One * 3, Q16One, '0, '0, 17'd32768,
                             MatOne, '0, '0, MatOne, Q16One * 10, '0, 1'b0));
    send_influence(influence(Q16One * 3, Q16One, Q16One / 2, '0, 17'd32768,
                             '0, -MatOne, MatOne, '0, '0, -Q16One * 5, 1'b1));
    // zero weight drops even the largest influence
    send_influence(influence(Q16Max, Q16Min, Q16Max, Q16Min, '0,
                             MatMax, MatMin, MatMin, MatMax, Q16Max, Q16Min, 1'b1));
    // weight above one, up to the top of the field
    send_influence(influence(Q16One * 7, -Q16One * 3, '0, '0, WTop,
                             MatOne, '0, '0, MatOne, Q16One, Q16One, 1'b1));
    send_influence(influence(Q16One, Q16One, '0, '0, 17'd65537,
                             MatOne, MatOne, '0, MatOne, '0, '0, 1'b1));
    // vertex sum beyond 32 bits, matrix and bone corners on both signs
    send_influence(influence(Q16Max, Q16Max, Q16Max, Q16Max, WUnit,
                             MatMax, MatMax, MatMax, MatMax, Q16Max, Q16Max, 1'b1));
    send_influence(influence(Q16Min, Q16Min, Q16Min, Q16Min, 17'd1,
                             MatMin, MatMin, MatMin, MatMin, Q16Min, Q16Min, 1'b1));
    send_influence(influence(Q16Max, Q16Min, Q16Min, Q16Max, WTop,
                             MatMax, MatMin, MatMin, MatMax, Q16Min, Q16Max, 1'b1));
    // rounding ties: half an lsb goes up on both signs
    send_influence(influence(32'h0000_8000, 32'hFFFF_8000, '0, '0, WUnit,
                             24'd1, '0, '0, 24'd1, '0, '0, 1'b1));
    send_influence(influence('0, '0, '0, '0, 17'd32768,
                             '0, '0, '0, '0, 32'd1, 32'hFFFF_FFFF, 1'b1));
    send_influence(influence('0, '0, '0, '0, 17'd32768,
                             '0, '0, '0, '0, 32'd3, 32'hFFFF_FFFD, 1'b1));
    // three influences blending one vertex
    send_influence(influence(Q16One * 20, Q16One * 4, Q16One, '0, 17'd20000,
                             MatOne, 24'h00_8000, '0, MatOne, Q16One * 100, '0, 1'b0));
    send_influence(influence(Q16One * 20, Q16One * 4, '0, '0, 17'd30000,
                             24'hFF_8000, '0, MatOne, '0, '0, -Q16One * 100, 1'b0));
    send_influence(influence(-Q16One * 2, Q16One * 9, '0, Q16One, 17'd15536,
                             '0, MatOne, MatOne, '0, Q16One * 5, Q16One * 5, 1'b1));
  endtask

  // translation pushes the result past both ends of the 32-bit range
  task automatic test_output_saturation();
    set_translation(Q16Max, Q16Min);
    send_influence(influence('0, '0, '0, '0, WUnit, '0, '0, '0, '0, '0, '0, 1'b1));
    send_influence(influence('0, '0, '0, '0, WUnit,
                             '0, '0, '0, '0, Q16One, -Q16One, 1'b1));
    set_translation(Q16Min, Q16Max);
    send_influence(influence('0, '0, '0, '0, WUnit,
                             '0, '0, '0, '0, -Q16One, Q16One, 1'b1));
    send_influence(influence('0, '0, '0, '0, WUnit,
                             '0, '0, '0, '0, Q16One * 3, -Q16One * 3, 1'b1));
  endtask

  // long chains of the largest influences drive the 48-bit sums into their clamps;
  // climbing back down from the clamp lands on the other side of zero
  task automatic test_accumulator_saturation();
    wvs_pkg::in_item_t up_step, down_step;
    set_translation('0, '0);
    gaps_on   = 1'b1;
    stall_pct = 30;
    up_step   = influence(Q16Min, Q16Min, Q16Min, Q16Min, WTop,
                          MatMin, MatMin, MatMin, MatMin, Q16Max, Q16Max, 1'b0);
    down_step = influence(Q16Min, Q16Min, Q16Min, Q16Min, WTop,
                          MatMax, MatMax, MatMax, MatMax, Q16Min, Q16Min, 1'b0);
    repeat (80) send_influence(up_step);
    repeat (65) send_influence(down_step);
    down_step.last_influence = 1'b1;
    send_influence(down_step);
    down_step.last_influence = 1'b0;
    repeat (69) send_influence(down_step);
    down_step.last_influence = 1'b1;
    send_influence(down_step);
  endtask

  // random vertices of one to four influences, now and then a longer one;
  // a quarter are full-range, in the rest most influences look like a real mesh
  task automatic test_random_vertices(input int n_items, input bit idle_on,
                                      input int stall_in, input int span_in);
    int sent, n, k;
    bit wide;
    gaps_on    = idle_on;
    stall_pct  = stall_in;
    stall_span = span_in;
    sent       = 0;
    while (sent < n_items) begin
      n    = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      wide = ($urandom_range(0, 3) == 0);
      for (k = 0; k < n; k++) begin
        send_influence(random_influence(wide || ($urandom_range(0, 9) == 0), k == n - 1));
        sent++;
      end
      // now and then let the block run dry before the next vertex
      if ($urandom_range(0, 11) == 0) wait_for_results();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_output_saturation();
    test_accumulator_saturation();

    set_translation(32'h0001_8000, 32'hFFFD_C000);
    test_random_vertices(170, 1'b1, 30, 6);
    // no idling on either side
    set_translation($urandom, $urandom);
    test_random_vertices(170, 1'b0, 0, 6);
    // heavy back-pressure with long stalls
    set_translation(Q16Max, Q16Min);
    test_random_vertices(170, 1'b1, 70, 30);
    set_translation(Q16Min, Q16Max);
    test_random_vertices(170, 1'b1, 40, 12);

    wait_for_results();
    repeat (DrainCycles) @(posedge clk);

    if (expected_world.size() != 0)
      report_mismatch("world positions never delivered", expected_world.size(), '0);
    $display("run covered %0d influence beats, %0d result beats, %0d translation settings",
             influences_sent, results_checked, settings_applied);
    $display("sums clamped on %0d beats, world positions clamped on %0d results",
             sum_clamps, world_clamps);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
